/* rtl/core/pscf_pkg.sv */
// Package for the packet serial CRC framer: item codes, result beat type,
// CRC-16/XMODEM constants and the byte fold function.
// No dependencies.
package pscf_pkg;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_SEND  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_RECV  = 3'd3,
    KIND_CHECK = 3'd4
  } kind_e;

  typedef enum logic {
    RES_TX      = 1'b0,
    RES_VERDICT = 1'b1
  } res_kind_e;

  typedef struct packed {
    res_kind_e   result_kind;
    logic [7:0]  tx_byte;
    logic        crc_match;
    logic        last;
  } result_t;

  localparam logic [15:0] CrcPoly   = 16'h1021;
  localparam logic [15:0] CrcTop    = 16'h8000;
  localparam logic [7:0]  AddrReset = 8'd128;

  // Fold one byte into the CRC, MSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/core/pscf_if.sv */
// Valid/ready channel interfaces for the packet serial CRC framer:
// input items, result beats and the address register write port.
// No dependencies.
interface pscf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;

  modport source (output valid, output kind, output data, input ready);
  modport sink   (input valid, input kind, input data, output ready);
endinterface

interface pscf_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] tx_byte;
  logic       crc_match;
  logic       last;

  modport source (output valid, output result_kind, output tx_byte, output crc_match,
                  output last, input ready);
  modport sink   (input valid, input result_kind, input tx_byte, input crc_match,
                  input last, output ready);
endinterface

interface pscf_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/packet_serial_crc_framer.sv */
// Channel  | dir | payload                                  | beat
// cfg_i    | in  | data: device address                     | one register write
// in_i     | in  | kind, data                               | one item
// out_o    | out | result_kind, tx_byte, crc_match, last     | one result
//
// An item is held in the input register, then its results load a two-entry result
// buffer. Items with no result or one result go through at one per cycle while the
// output is not stalled; start and close give two beats each at the output port.
// Reset clears the CRC, the checksum phase and the buffer and loads address 128.
// A stalled output holds its beat; the input keeps ready while the buffer can drain.
// Depends on pscf_pkg and pscf_if.
module packet_serial_crc_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  pscf_cfg_if.sink    cfg_i,
  pscf_in_if.sink     in_i,
  pscf_out_if.source  out_o
);
  import pscf_pkg::*;

  localparam logic [15:0] AddrCrcReset = crc_fold(16'h0000, AddrReset);

  logic [7:0]  addr_q;
  logic [15:0] addr_crc_q;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  chk_hi_q, chk_hi_d;
  logic        chk_phase_q, chk_phase_d;

  logic        stg_vld_q;
  logic [2:0]  stg_kind_q;
  logic [7:0]  stg_data_q;
  kind_e       kind;

  result_t     res_q [2];
  logic [1:0]  cnt_q;
  result_t     r0, r1;
  logic [1:0]  nres;

  logic        pop, room, proc, acc;

  assign kind = kind_e'(stg_kind_q);

  always_comb begin
    r0          = '0;
    r1          = '0;
    nres        = 2'd0;
    crc_d       = crc_q;
    chk_hi_d    = chk_hi_q;
    chk_phase_d = chk_phase_q;
    case (kind)
      KIND_START: begin
        r0.tx_byte  = addr_q;
        r1.tx_byte  = stg_data_q;
        r1.last     = 1'b1;
        nres        = 2'd2;
        crc_d       = crc_fold(addr_crc_q, stg_data_q);
        chk_phase_d = 1'b0;
      end
      KIND_SEND: begin
        r0.tx_byte = stg_data_q;
        r0.last    = 1'b1;
        nres       = 2'd1;
        crc_d      = crc_fold(crc_q, stg_data_q);
      end
      KIND_CLOSE: begin
        r0.tx_byte = crc_q[15:8];
        r1.tx_byte = crc_q[7:0];
        r1.last    = 1'b1;
        nres       = 2'd2;
        // folding a CRC behind its own message leaves zero
        crc_d      = 16'h0000;
      end
      KIND_RECV: begin
        crc_d = crc_fold(crc_q, stg_data_q);
      end
      KIND_CHECK: begin
        if (!chk_phase_q) begin
          chk_hi_d    = stg_data_q;
          chk_phase_d = 1'b1;
        end else begin
          r0.result_kind = RES_VERDICT;
          r0.crc_match   = ({chk_hi_q, stg_data_q} == crc_q);
          r0.last        = 1'b1;
          nres           = 2'd1;
          chk_phase_d    = 1'b0;
        end
      end
      default: begin
        nres = 2'd0;
      end
    endcase
  end

  assign pop  = (cnt_q != 2'd0) && out_o.ready;
  assign room = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
  assign proc = stg_vld_q && ((nres == 2'd0) || room);
  assign acc  = in_i.valid && in_i.ready;

  assign in_i.ready  = !stg_vld_q || proc;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= AddrReset;
      addr_crc_q  <= AddrCrcReset;
      crc_q       <= 16'h0000;
      chk_hi_q    <= 8'h00;
      chk_phase_q <= 1'b0;
      stg_vld_q   <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      if (cfg_i.valid) begin
        addr_q     <= cfg_i.data;
        addr_crc_q <= crc_fold(16'h0000, cfg_i.data);
      end
      if (acc) begin
        stg_vld_q <= 1'b1;
      end else if (proc) begin
        stg_vld_q <= 1'b0;
      end
      if (proc) begin
        crc_q       <= crc_d;
        chk_hi_q    <= chk_hi_d;
        chk_phase_q <= chk_phase_d;
      end
      if (proc && (nres != 2'd0)) begin
        cnt_q <= nres;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      stg_kind_q <= in_i.kind;
      stg_data_q <= in_i.data;
    end
    if (proc && (nres != 2'd0)) begin
      res_q[0] <= r0;
      res_q[1] <= r1;
    end else if (pop) begin
      // advance the second beat to the head
      res_q[0] <= res_q[1];
    end
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.result_kind = res_q[0].result_kind;
  assign out_o.tx_byte     = res_q[0].tx_byte;
  assign out_o.crc_match   = res_q[0].crc_match;
  assign out_o.last        = res_q[0].last;

endmodule

/* rtl/core/pscf_checker.sv */
// Port-level checks for the packet serial CRC framer, bound to the top level.
// Depends on pscf_pkg and packet_serial_crc_framer.
module pscf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_result_kind,
  input logic [7:0] out_tx_byte,
  input logic       out_crc_match,
  input logic       out_last
);
  import pscf_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte) &&
    $stable(out_result_kind) && $stable(out_crc_match) && $stable(out_last))
    else $error("result beat changed while stalled");

  // input backpressure only while results are pending
  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

  a_verdict_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_result_kind == RES_VERDICT) |-> out_last && (out_tx_byte == 8'h00))
    else $error("verdict beat malformed");

  a_tx_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (out_result_kind == RES_TX) |-> !out_crc_match)
    else $error("transmit beat carries match flag");

endmodule

bind packet_serial_crc_framer pscf_checker u_pscf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_result_kind (out_o.result_kind),
  .out_tx_byte     (out_o.tx_byte),
  .out_crc_match   (out_o.crc_match),
  .out_last        (out_o.last)
);

/* dv/tb_packet_serial_crc_framer.sv */
// Self-checking testbench for packet_serial_crc_framer: write and read packets with
// random content, noise items, address changes and random idling on both channels.
// Depends on pscf_pkg and the pscf_if channel interfaces.
`timescale 1ns / 1ps

module tb_packet_serial_crc_framer;
  import pscf_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned PhaseItems   = 160;
  localparam int unsigned NumPhases    = 8;
  localparam int unsigned QuietPhases  = 2;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxPrinted   = 30;

  // Mirror of the framer: CRC, checksum capture and the queue of beats still due.
  class framer_scoreboard;
    logic [7:0]  dev_addr;
    logic [15:0] crc;
    logic [7:0]  chk_hi;
    logic        chk_phase;
    result_t     due_q[$];
    int unsigned errors;

    function new();
      dev_addr  = AddrReset;
      crc       = '0;
      chk_hi    = '0;
      chk_phase = 1'b0;
      errors    = 0;
    endfunction

    static function logic [15:0] fold(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      repeat (8) r = r[15] ? ((r << 1) ^ CrcPoly) : (r << 1);
      return r;
    endfunction

    // Every transmitted byte goes into the CRC as it leaves.
    function void push_tx(logic [7:0] b, logic last_beat);
      result_t r;
      crc = fold(crc, b);
      r.result_kind = RES_TX;
      r.tx_byte     = b;
      r.crc_match   = 1'b0;
      r.last        = last_beat;
      due_q.push_back(r);
    endfunction

    function void note_item(logic [2:0] kind, logic [7:0] data);
      result_t     r;
      logic [15:0] snap;
      case (kind)
        KIND_START: begin
          crc       = '0;
          chk_phase = 1'b0;
          push_tx(dev_addr, 1'b0);
          push_tx(data, 1'b1);
        end
        KIND_SEND: push_tx(data, 1'b1);
        KIND_CLOSE: begin
          snap = crc;
          push_tx(snap[15:8], 1'b0);
          push_tx(snap[7:0], 1'b1);
        end
        KIND_RECV: crc = fold(crc, data);
        KIND_CHECK: begin
          if (!chk_phase) begin
            chk_hi    = data;
            chk_phase = 1'b1;
          end else begin
            chk_phase     = 1'b0;
            r.result_kind = RES_VERDICT;
            r.tx_byte     = '0;
            r.crc_match   = ({chk_hi, data} == crc);
            r.last        = 1'b1;
            due_q.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      if (errors < MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected beat kind=%0b byte=%02h match=%0b last=%0b",
                         got.result_kind, got.tx_byte, got.crc_match, got.last));
        return;
      end
      want = due_q.pop_front();
      if (got.result_kind !== want.result_kind || got.tx_byte !== want.tx_byte ||
          got.crc_match !== want.crc_match || got.last !== want.last) begin
        report($sformatf("got kind=%0b byte=%02h match=%0b last=%0b, want %0b %02h %0b %0b",
                         got.result_kind, got.tx_byte, got.crc_match, got.last,
                         want.result_kind, want.tx_byte, want.crc_match, want.last));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pscf_cfg_if cfg_if ();
  pscf_in_if  in_if ();
  pscf_out_if out_if ();

  packet_serial_crc_framer DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  framer_scoreboard sb = new();

  logic [7:0]  cur_addr  = AddrReset;
  bit          in_gaps   = 1'b0;
  bit          out_stalls = 1'b0;
  int unsigned cycles    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** packet_serial_crc_framer: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t beat;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.dev_addr = cfg_if.data;
      if (in_if.valid && in_if.ready) sb.note_item(in_if.kind, in_if.data);
      if (out_if.valid && out_if.ready) begin
        beat.result_kind = res_kind_e'(out_if.result_kind);
        beat.tx_byte     = out_if.tx_byte;
        beat.crc_match   = out_if.crc_match;
        beat.last        = out_if.last;
        sb.check_beat(beat);
      end
    end
  end

  // Result side: stall in random bursts while enabled.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_stalls && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  // Present one item; return at the edge where it is taken, valid still high.
  task automatic send_item(logic [2:0] kind, logic [7:0] data);
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.data  <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every due beat is out and the pipeline is empty.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_address(logic [7:0] addr);
    settle();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= addr;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cur_addr = addr;
  endtask

  task automatic write_packet(int unsigned n);
    send_item(KIND_START, 8'($urandom_range(0, 255)));
    repeat (n) send_item(KIND_SEND, 8'($urandom_range(0, 255)));
    send_item(KIND_CLOSE, 8'($urandom_range(0, 255)));
  endtask

  task automatic read_packet(int unsigned n, bit corrupt);
    logic [7:0]  cmd;
    logic [7:0]  b;
    logic [15:0] c;
    cmd = 8'($urandom_range(0, 255));
    c = framer_scoreboard::fold(framer_scoreboard::fold(16'h0000, cur_addr), cmd);
    send_item(KIND_START, cmd);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      c = framer_scoreboard::fold(c, b);
      send_item(KIND_RECV, b);
    end
    if (corrupt) c = c ^ 16'($urandom_range(1, 65535));
    send_item(KIND_CHECK, c[15:8]);
    send_item(KIND_CHECK, c[7:0]);
  endtask

  task automatic directed_items();
    logic [15:0] c;
    send_item(KIND_START, 8'h00);
    send_item(KIND_SEND, 8'hFF);
    send_item(KIND_SEND, 8'h00);
    send_item(KIND_CLOSE, 8'hFF);
    // well-formed response, checksum matches
    c = framer_scoreboard::fold(framer_scoreboard::fold(16'h0000, cur_addr), 8'hFF);
    c = framer_scoreboard::fold(framer_scoreboard::fold(c, 8'h00), 8'hFF);
    send_item(KIND_START, 8'hFF);
    send_item(KIND_RECV, 8'h00);
    send_item(KIND_RECV, 8'hFF);
    send_item(KIND_CHECK, c[15:8]);
    send_item(KIND_CHECK, c[7:0]);
    send_item(KIND_START, 8'h5A);
    send_item(KIND_CHECK, 8'h00);
    send_item(KIND_CHECK, 8'h00);
    // a start drops a half-received checksum
    c = framer_scoreboard::fold(framer_scoreboard::fold(16'h0000, cur_addr), 8'h11);
    send_item(KIND_CHECK, 8'hAB);
    send_item(KIND_START, 8'h11);
    send_item(KIND_CHECK, c[15:8]);
    send_item(KIND_CHECK, c[7:0]);
    for (int k = KIND_CHECK + 1; k < 8; k++) send_item(3'(k), 8'(k * 8'h33));
    // second close sends zeros, CRC read back after a receive
    send_item(KIND_CLOSE, 8'h00);
    send_item(KIND_CLOSE, 8'hFF);
    c = framer_scoreboard::fold(16'h0000, 8'hFF);
    send_item(KIND_RECV, 8'hFF);
    send_item(KIND_CHECK, c[15:8]);
    send_item(KIND_CHECK, c[7:0]);
  endtask

  task automatic random_phase(int unsigned quota);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 9);
      n    = $urandom_range(0, 8);
      if (pick < 4) begin
        write_packet(n);
        sent += n + 2;
      end else if (pick < 8) begin
        read_packet(n, $urandom_range(0, 3) == 0);
        sent += n + 3;
      end else begin
        repeat (n / 2 + 1) send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
        sent += n / 2 + 1;
      end
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= KIND_START;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_items();
    for (int p = 0; p < NumPhases; p++) begin
      write_address(p == 0 ? 8'h00 : p == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
      in_gaps    = (p < NumPhases - QuietPhases) && ($urandom_range(0, 3) != 0);
      out_stalls = (p < NumPhases - QuietPhases) && ($urandom_range(0, 3) != 0);
      random_phase(PhaseItems);
    end
    settle();

    if (sb.errors == 0) begin
      $display("** packet_serial_crc_framer: PASSED **");
    end else begin
      $display("** packet_serial_crc_framer: FAILED **");
    end
    $finish;
  end

endmodule
